// ----- rtl/ectd_pkg.sv -----
// Shared types, constants and helper functions for the epoch-seconds to calendar converter.
`timescale 1ns / 1ps

package ectd_pkg;

  // Time unit constants.
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // Reciprocals for the three divisions. The day quotient is taken from the
  // timestamp shifted right by 7, since 86400 = 128 * 675. Each reciprocal is
  // rounded up and is exact over the range of its dividend.
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // ceil(2^35 / 675)
  localparam logic [17:0] RECIP_HOUR = 18'd149131;    // ceil(2^29 / 3600)
  localparam logic [12:0] RECIP_MIN  = 13'd4370;      // ceil(2^18 / 60)

  // Calendar origin: 1970-01-01 was a Thursday (Monday is zero).
  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  localparam logic [1:0]  BASE_YEAR_M4  = 2'd2;
  localparam logic [6:0]  BASE_YEAR_M100 = 7'd70;
  localparam logic [8:0]  BASE_YEAR_M400 = 9'd370;
  localparam logic [2:0]  BASE_WEEKDAY  = 3'd3;

  localparam logic [6:0]  LAST_M100 = 7'd99;
  localparam logic [8:0]  LAST_M400 = 9'd399;
  localparam logic [3:0]  MONTH_FEB = 4'd1;
  localparam logic [3:0]  MONTH_DEC = 4'd11;

  localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;
  localparam logic [8:0]  DAYS_LEAP_YEAR   = 9'd366;

  // Which constant the shared divider works against.
  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_step;
    logic     year_step;
    logic     month_step;
    logic     capture;
  } ectd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic year_done;
    logic month_done;
  } ectd_sts_t;

  // Length of a month in days; February follows the leap flag.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd0:      d = 5'd31;
      MONTH_FEB: d = leap ? 5'd29 : 5'd28;
      4'd2:      d = 5'd31;
      4'd3:      d = 5'd30;
      4'd4:      d = 5'd31;
      4'd5:      d = 5'd30;
      4'd6:      d = 5'd31;
      4'd7:      d = 5'd31;
      4'd8:      d = 5'd30;
      4'd9:      d = 5'd31;
      4'd10:     d = 5'd30;
      4'd11:     d = 5'd31;
      default:   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar_date.sv -----
// Top level of the epoch-seconds to Gregorian calendar date converter.
`timescale 1ns / 1ps

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC, shifted by the
// whole-hour zone offset and saturated to the 32-bit range, into year, month, day,
// hour, minute, second and weekday (0 = Monday). One word is converted at a time:
// the time a conversion takes is set mostly by the year loop, which removes one year
// of 365 or 366 days per cycle (up to 136 years), then by the month loop (up to 11
// months), the day, hour and minute divisions by reciprocal multiplication, each a
// quotient step and a remainder step, the exits of the year and month loops, the step
// between the hour and minute divisions and the hand-over to the result register.
// The hand-over waits while the previous result is still stalled. A new input word
// is taken while the previous result still waits in the output register. The offset
// register is always ready and should be written only while no conversion is in flight.
module epoch_seconds_to_calendar_date import ectd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_index_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [2:0]  weekday_o
);

  ectd_cmd_t cmd;
  ectd_sts_t sts;

  // The offset register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  ectd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ectd_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .epoch_seconds_i    (epoch_seconds_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .year_o             (year_o),
    .month_index_o      (month_index_o),
    .day_of_month_o     (day_of_month_o),
    .hour_of_day_o      (hour_of_day_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .second_of_minute_o (second_of_minute_o),
    .weekday_o          (weekday_o)
  );

endmodule

// ----- rtl/ectd_datapath.sv -----
// Datapath: offset and saturation, shared reciprocal divider, year and month loops.
`timescale 1ns / 1ps

module ectd_datapath import ectd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  input  logic [31:0] epoch_seconds_i,
  input  ectd_cmd_t   cmd_i,
  output ectd_sts_t   sts_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_index_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [2:0]  weekday_o
);

  logic [4:0]  zone_q;
  logic [31:0] rem_q, rem_d;
  logic        ph_q, ph_d;
  logic [15:0] quo_q, quo_d;
  logic [2:0]  wd_q, wd_d;
  div_sel_e    sel_q, sel_d;
  logic [11:0] yr_q, yr_d;
  logic [1:0]  y4_q, y4_d;
  logic [6:0]  y100_q, y100_d;
  logic [8:0]  y400_q, y400_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;

  // Time-zone offset register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
    end else if (cfg_we_i) begin
      zone_q <= cfg_data_i;
    end
  end

  // Offset in seconds and saturation of the shifted timestamp to 32 bits.
  logic signed [17:0] zone_secs;
  logic signed [33:0] sum;
  logic [31:0]        sat;
  assign zone_secs = 18'(signed'(zone_q)) * signed'({1'b0, SECS_PER_HOUR});
  assign sum       = signed'({2'b00, epoch_seconds_i}) + 34'(zone_secs);
  always_comb begin
    if (sum[33]) begin
      sat = '0;
    end else if (sum[32]) begin
      sat = '1;
    end else begin
      sat = sum[31:0];
    end
  end

  // Division in two steps: first the quotient by reciprocal multiplication, then
  // the remainder by subtracting quotient times divisor.
  logic [16:0] divisor;
  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [50:0] prod;
  logic [15:0] quo_rc;
  logic [32:0] qd;
  always_comb begin
    case (sel_q)
      DIV_DAY: begin
        divisor = SECS_PER_DAY;
        mul_a   = rem_q[31:7];
        mul_b   = RECIP_DAY;
      end
      DIV_HOUR: begin
        divisor = SECS_PER_HOUR;
        mul_a   = {8'b0, rem_q[16:0]};
        mul_b   = {8'b0, RECIP_HOUR};
      end
      DIV_MIN: begin
        divisor = SECS_PER_MIN;
        mul_a   = {13'b0, rem_q[11:0]};
        mul_b   = {13'b0, RECIP_MIN};
      end
      default: begin
        divisor = SECS_PER_MIN;
        mul_a   = {13'b0, rem_q[11:0]};
        mul_b   = {13'b0, RECIP_MIN};
      end
    endcase
  end
  assign prod = {26'b0, mul_a} * {25'b0, mul_b};
  always_comb begin
    case (sel_q)
      DIV_DAY:  quo_rc = prod[50:35];
      DIV_HOUR: quo_rc = prod[44:29];
      DIV_MIN:  quo_rc = prod[33:18];
      default:  quo_rc = prod[33:18];
    endcase
  end
  assign qd = {17'b0, quo_q} * {16'b0, divisor};

  // Day count modulo seven: eight is one modulo seven, so octal digits are summed.
  logic [5:0] wd_s1;
  logic [3:0] wd_s2;
  logic [2:0] wd_mod;
  assign wd_s1  = {3'b0, quo_q[2:0]} + {3'b0, quo_q[5:3]} + {3'b0, quo_q[8:6]}
                + {3'b0, quo_q[11:9]} + {3'b0, quo_q[14:12]} + {5'b0, quo_q[15]};
  assign wd_s2  = {1'b0, wd_s1[2:0]} + {1'b0, wd_s1[5:3]};
  assign wd_mod = (wd_s2 >= 4'd7) ? 3'(wd_s2 - 4'd7) : wd_s2[2:0];

  // Leap year from the running residues of the year counter.
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  assign leap = ((y4_q == 2'd0) && (y100_q != 7'd0)) || (y400_q == 9'd0);
  assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
  assign mlen = month_days(mon_q, leap);

  assign sts_o.div_last   = ph_q;
  assign sts_o.year_done  = (quo_q < {7'b0, ylen});
  assign sts_o.month_done = (mon_q == MONTH_DEC) || (quo_q < {11'b0, mlen});

  // Next-state logic of the working registers.
  always_comb begin
    rem_d  = rem_q;
    ph_d   = ph_q;
    quo_d  = quo_q;
    wd_d   = wd_q;
    sel_d  = sel_q;
    yr_d   = yr_q;
    y4_d   = y4_q;
    y100_d = y100_q;
    y400_d = y400_q;
    mon_d  = mon_q;
    day_d  = day_q;
    hour_d = hour_q;
    if (cmd_i.load) begin
      rem_d  = sat;
      ph_d   = 1'b0;
      quo_d  = '0;
      wd_d   = '0;
      sel_d  = DIV_DAY;
      yr_d   = BASE_YEAR;
      y4_d   = BASE_YEAR_M4;
      y100_d = BASE_YEAR_M100;
      y400_d = BASE_YEAR_M400;
      mon_d  = '0;
    end else if (cmd_i.div_start) begin
      sel_d = cmd_i.div_sel;
      quo_d = '0;
      ph_d  = 1'b0;
      if (cmd_i.div_sel == DIV_HOUR) begin
        day_d = quo_q[4:0] + 5'd1;
      end else begin
        hour_d = quo_q[4:0];
      end
    end else if (cmd_i.div_step) begin
      ph_d = !ph_q;
      if (!ph_q) begin
        quo_d = quo_rc;
      end else begin
        rem_d = rem_q - qd[31:0];
        // The weekday residue is taken once the day count is known.
        if (sel_q == DIV_DAY) begin
          wd_d = wd_mod;
        end
      end
    end else if (cmd_i.year_step) begin
      quo_d  = quo_q - {7'b0, ylen};
      yr_d   = yr_q + 12'd1;
      y4_d   = y4_q + 2'd1;
      y100_d = (y100_q == LAST_M100) ? 7'd0 : y100_q + 7'd1;
      y400_d = (y400_q == LAST_M400) ? 9'd0 : y400_q + 9'd1;
    end else if (cmd_i.month_step) begin
      quo_d = quo_q - {11'b0, mlen};
      mon_d = mon_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    ph_q   <= ph_d;
    quo_q  <= quo_d;
    wd_q   <= wd_d;
    sel_q  <= sel_d;
    yr_q   <= yr_d;
    y4_q   <= y4_d;
    y100_q <= y100_d;
    y400_q <= y400_d;
    mon_q  <= mon_d;
    day_q  <= day_d;
    hour_q <= hour_d;
  end

  // Output word register, loaded when the controller hands over a result.
  logic [3:0] wd_off;
  assign wd_off = {1'b0, wd_q} + {1'b0, BASE_WEEKDAY};
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      year_o             <= yr_q;
      month_index_o      <= mon_q;
      day_of_month_o     <= day_q;
      hour_of_day_o      <= hour_q;
      minute_of_hour_o   <= quo_q[5:0];
      second_of_minute_o <= rem_q[5:0];
      weekday_o          <= (wd_off >= 4'd7) ? 3'(wd_off - 4'd7) : wd_off[2:0];
    end
  end

endmodule

// ----- rtl/ectd_ctrl.sv -----
// Controller: sequences the division, year and month loops and the output handshake.
`timescale 1ns / 1ps

module ectd_ctrl import ectd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ectd_sts_t sts_i,
  output ectd_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DAY    = 3'd1;
  localparam logic [2:0] S_YEAR   = 3'd2;
  localparam logic [2:0] S_MONTH  = 3'd3;
  localparam logic [2:0] S_HOUR   = 3'd4;
  localparam logic [2:0] S_MSTART = 3'd5;
  localparam logic [2:0] S_MIN    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // State transitions and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_HOUR;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DAY;
        end
      end
      S_DAY: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sts_i.year_done) begin
          state_d = S_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (sts_i.month_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_HOUR;
          state_d         = S_HOUR;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      S_HOUR: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MIN;
        state_d         = S_MIN;
      end
      S_MIN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
